### design/shifting_array_list_top_assert.svh
// Assertion macros for the ordered list block.
// Used by the checker module; expects clk and rst in the including scope.
`ifndef SHIFTING_ARRAY_LIST_TOP_ASSERT_SVH
`define SHIFTING_ARRAY_LIST_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SLA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list check failed");

// Consequent checked in the cycle after the antecedent
`define SLA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list check failed");

`endif

### design/sla_pkg.sv
// Shared types and constants for the ordered list block.
// No dependencies; used by every module of the block except sla_first.
package sla_pkg;

  // Parameter defaults
  localparam int CAPACITY_DEF     = 32;
  localparam int KEY_BITS_DEF     = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int FIELD_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Request word layout
  localparam int S_TDATA_W   = 80;
  localparam int IN_OP_LSB   = 0;
  localparam int IN_POS_LSB  = 3;
  localparam int IN_END_LSB  = 8;
  localparam int IN_KEY_LSB  = 9;
  localparam int IN_PAY_LSB  = 41;

  // Result word layout
  localparam int M_TDATA_W      = 80;
  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_FOUND_LSB  = 2;
  localparam int OUT_KEY_LSB    = 7;
  localparam int OUT_PAY_LSB    = 39;
  localparam int OUT_COUNT_LSB  = 71;
  localparam int OUT_EMPTY_LSB  = 77;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_READ   = 3'd2,
    OP_UPDATE = 3'd3,
    OP_FIND   = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // What a cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      live;     // cell index below the entry count
    logic      compare;  // capture key match this cycle
  } cell_ctl_t;

endpackage

### design/sla_cell.sv
// One entry of the ordered list: key, payload and a registered match flag.
// Depends on sla_pkg for the cell control struct.
module sla_cell #(
  parameter int KEY_BITS     = sla_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = sla_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                    clk,
  input  sla_pkg::cell_ctl_t      ctl,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic [KEY_BITS-1:0]     lower_key,
  input  logic [PAYLOAD_BITS-1:0] lower_payload,
  input  logic [KEY_BITS-1:0]     upper_key,
  input  logic [PAYLOAD_BITS-1:0] upper_payload,
  input  logic [KEY_BITS-1:0]     cmp_key,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload,
  output logic                    match
);

  // Entry storage: load, shift from a neighbor or hold
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      sla_pkg::CELL_LOAD: begin
        key     <= new_key;
        payload <= new_payload;
      end
      sla_pkg::CELL_FROM_LOWER: begin
        key     <= lower_key;
        payload <= lower_payload;
      end
      sla_pkg::CELL_FROM_UPPER: begin
        key     <= upper_key;
        payload <= upper_payload;
      end
      default: begin
      end
    endcase
    // key compare for find, only valid entries count
    if (ctl.compare) begin
      match <= ctl.live && (key == cmp_key);
    end
  end

endmodule

### design/sla_first.sv
// Lowest-index hit encoder over the row of cell match flags.
// Standalone; no package use.
module sla_first #(
  parameter int N = 32
) (
  input  logic [N-1:0]            hits,
  output logic                    any,
  output logic [$clog2(N)-1:0]    index
);

  localparam int IW = $clog2(N);

  logic [N-1:0] lowest;

  // isolate lowest set bit, then OR its index
  assign lowest = hits & (~hits + N'(1));
  assign any    = |hits;

  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      if (lowest[i]) begin
        index = index | IW'(i);
      end
    end
  end

endmodule

### design/shifting_array_list_top.sv
// Ordered list of key/payload entries held in a row of shifting cells.
// Depends on sla_pkg, sla_cell and sla_first.
//
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata, one operation each: insert
//   (at a position or appended), delete, read, update, find, clear. Every
//   request yields exactly one result on m_tvalid/m_tready/m_tdata.
//   Each request passes the three-step sequencer (capture, a step in which
//   all cells shift or compare in parallel, a step for the first-match
//   encode and result build), and the next request is taken only after
//   the build step has loaded the result into the output register.
//   s_tready is high only while the sequencer is idle; a new request may be
//   taken while the previous result still waits in the output register.
//   When the receiver stalls, the finished result waits in the build step
//   until the output register frees, and no new request is taken meanwhile.
//   Reset clears the entry count and the output valid; entry contents are
//   not cleared and are never read before being written.
module shifting_array_list_top #(
  parameter int CAPACITY     = sla_pkg::CAPACITY_DEF,
  parameter int KEY_BITS     = sla_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = sla_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // operation[2:0], position[7:3], at_end[8], item_key[40:9],
  // item_payload[72:41], zero pad[79:73]
  input  logic [sla_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status[1:0], found_position[6:2], read_key[38:7], read_payload[70:39],
  // entry_count[76:71], list_empty[77], zero pad[79:78]
  output logic [sla_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > sla_pkg::COUNT_W) ? CNT_W : sla_pkg::COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              count;
  logic [sla_pkg::OP_W-1:0]      req_op;
  logic [sla_pkg::POS_W-1:0]     req_pos;
  logic                          req_end;
  logic [KEY_BITS-1:0]           req_key;
  logic [PAYLOAD_BITS-1:0]       req_payload;
  sla_pkg::status_t              res_status;
  logic [KEY_BITS-1:0]           res_key;
  logic [PAYLOAD_BITS-1:0]       res_payload;

  // execute-step decode
  logic                          exec;
  logic [CMP_W-1:0]              pos_ext;
  logic [CMP_W-1:0]              cnt_ext;
  logic [CMP_W-1:0]              wr_tgt;
  logic                          full;
  logic                          pos_ok;
  logic                          ins_ok;
  logic                          del_ok;
  logic                          upd_ok;
  logic                          rd_ok;
  logic                          find_go;
  sla_pkg::status_t              exec_status;
  logic [CNT_W-1:0]              count_next;

  // cell row
  sla_pkg::cell_ctl_t            ctl      [CAPACITY];
  logic [KEY_BITS-1:0]           cell_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0]       cell_pay [CAPACITY];
  logic [CAPACITY-1:0]           hits;
  logic                          hit_any;
  logic [IDX_W-1:0]              hit_idx;

  // result build
  logic [CMP_W-1:0]              hit_ext;
  logic                          is_find;
  sla_pkg::status_t              out_status;
  logic [sla_pkg::POS_W-1:0]     out_found;
  logic [sla_pkg::M_TDATA_W-1:0] result_word;

  assign s_tready = (state == S_IDLE);
  assign exec     = (state == S_EXEC);
  assign pos_ext  = CMP_W'(req_pos);
  assign cnt_ext  = CMP_W'(count);
  assign full     = (count == CNT_W'(CAPACITY));
  assign pos_ok   = (pos_ext < cnt_ext);
  assign wr_tgt   = (ins_ok && req_end) ? cnt_ext : pos_ext;

  // operation decode against the current count
  always_comb begin
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    upd_ok      = 1'b0;
    rd_ok       = 1'b0;
    find_go     = 1'b0;
    exec_status = sla_pkg::ST_OK;
    count_next  = count;
    unique case (sla_pkg::op_t'(req_op))
      sla_pkg::OP_INSERT: begin
        if (full) begin
          exec_status = sla_pkg::ST_FULL;
        end else if (req_end || pos_ok) begin
          ins_ok     = 1'b1;
          count_next = count + CNT_W'(1);
        end else begin
          exec_status = sla_pkg::ST_BAD_POS;
        end
      end
      sla_pkg::OP_DELETE: begin
        if (pos_ok) begin
          del_ok     = 1'b1;
          count_next = count - CNT_W'(1);
        end else begin
          exec_status = sla_pkg::ST_BAD_POS;
        end
      end
      sla_pkg::OP_READ: begin
        if (pos_ok) begin
          rd_ok = 1'b1;
        end else begin
          exec_status = sla_pkg::ST_BAD_POS;
        end
      end
      sla_pkg::OP_UPDATE: begin
        if (pos_ok) begin
          upd_ok = 1'b1;
        end else begin
          exec_status = sla_pkg::ST_BAD_POS;
        end
      end
      sla_pkg::OP_FIND: begin
        find_go = 1'b1;
      end
      sla_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Row of cells, each steered by its index against target and count
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]     lo_key;
    logic [PAYLOAD_BITS-1:0] lo_pay;
    logic [KEY_BITS-1:0]     up_key;
    logic [PAYLOAD_BITS-1:0] up_pay;

    if (i == 0) begin : g_first
      assign lo_key = '0;
      assign lo_pay = '0;
    end else begin : g_mid_lo
      assign lo_key = cell_key[i-1];
      assign lo_pay = cell_pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign up_key = '0;
      assign up_pay = '0;
    end else begin : g_mid_up
      assign up_key = cell_key[i+1];
      assign up_pay = cell_pay[i+1];
    end

    always_comb begin
      ctl[i].cmd     = sla_pkg::CELL_HOLD;
      ctl[i].live    = (CMP_W'(i) < cnt_ext);
      ctl[i].compare = exec && find_go;
      if (exec) begin
        if (ins_ok) begin
          if (CMP_W'(i) == wr_tgt) begin
            ctl[i].cmd = sla_pkg::CELL_LOAD;
          end else if (CMP_W'(i) > wr_tgt) begin
            ctl[i].cmd = sla_pkg::CELL_FROM_LOWER;
          end
        end else if (upd_ok && (CMP_W'(i) == pos_ext)) begin
          ctl[i].cmd = sla_pkg::CELL_LOAD;
        end else if (del_ok && (CMP_W'(i) >= pos_ext)) begin
          ctl[i].cmd = sla_pkg::CELL_FROM_UPPER;
        end
      end
    end

    sla_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl[i]),
      .new_key       (req_key),
      .new_payload   (req_payload),
      .lower_key     (lo_key),
      .lower_payload (lo_pay),
      .upper_key     (up_key),
      .upper_payload (up_pay),
      .cmp_key       (req_key),
      .key           (cell_key[i]),
      .payload       (cell_pay[i]),
      .match         (hits[i])
    );
  end

  sla_first #(
    .N (CAPACITY)
  ) u_first (
    .hits  (hits),
    .any   (hit_any),
    .index (hit_idx)
  );

  // Result word from registered status, read data and match encode
  assign hit_ext = CMP_W'(hit_idx);
  assign is_find = (req_op == sla_pkg::OP_FIND);

  always_comb begin
    out_status = res_status;
    out_found  = '0;
    if (is_find) begin
      if (hit_any) begin
        out_status = sla_pkg::ST_OK;
        out_found  = hit_ext[sla_pkg::POS_W-1:0];
      end else begin
        out_status = sla_pkg::ST_NOT_FOUND;
      end
    end
    result_word = '0;
    result_word[sla_pkg::OUT_STATUS_LSB +: sla_pkg::STATUS_W] = out_status;
    result_word[sla_pkg::OUT_FOUND_LSB +: sla_pkg::POS_W]     = out_found;
    result_word[sla_pkg::OUT_KEY_LSB +: sla_pkg::FIELD_W]     = sla_pkg::FIELD_W'(res_key);
    result_word[sla_pkg::OUT_PAY_LSB +: sla_pkg::FIELD_W]     = sla_pkg::FIELD_W'(res_payload);
    result_word[sla_pkg::OUT_COUNT_LSB +: sla_pkg::COUNT_W]   = cnt_ext[sla_pkg::COUNT_W-1:0];
    result_word[sla_pkg::OUT_EMPTY_LSB]                       = (count == '0);
  end

  // Sequencer, request capture, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output valid: set when a result is loaded, cleared when taken
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_op      <= s_tdata[sla_pkg::IN_OP_LSB +: sla_pkg::OP_W];
            req_pos     <= s_tdata[sla_pkg::IN_POS_LSB +: sla_pkg::POS_W];
            req_end     <= s_tdata[sla_pkg::IN_END_LSB];
            req_key     <= s_tdata[sla_pkg::IN_KEY_LSB +: KEY_BITS];
            req_payload <= s_tdata[sla_pkg::IN_PAY_LSB +: PAYLOAD_BITS];
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          count      <= count_next;
          res_status <= exec_status;
          if (rd_ok) begin
            res_key     <= cell_key[pos_ext[IDX_W-1:0]];
            res_payload <= cell_pay[pos_ext[IDX_W-1:0]];
          end else begin
            res_key     <= '0;
            res_payload <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= result_word;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/sla_checker.sv
// Port-level checks for the ordered list block, bound to its top level.
// Depends on sla_pkg and shifting_array_list_top_assert.svh.
`include "shifting_array_list_top_assert.svh"

module sla_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sla_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [sla_pkg::STATUS_W-1:0] res_status;
  logic [sla_pkg::POS_W-1:0]    res_found;
  logic [sla_pkg::COUNT_W-1:0]  res_count;
  logic                         res_empty;

  assign res_status = m_tdata[sla_pkg::OUT_STATUS_LSB +: sla_pkg::STATUS_W];
  assign res_found  = m_tdata[sla_pkg::OUT_FOUND_LSB +: sla_pkg::POS_W];
  assign res_count  = m_tdata[sla_pkg::OUT_COUNT_LSB +: sla_pkg::COUNT_W];
  assign res_empty  = m_tdata[sla_pkg::OUT_EMPTY_LSB];

  // a stalled result is held unchanged
  `SLA_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // empty flag agrees with the reported count
  `SLA_ASSERT_NOW(a_empty_count, m_tvalid, res_empty == (res_count == '0))

  // a failed operation never reports a match position
  `SLA_ASSERT_NOW(a_found_zero, m_tvalid && (res_status != sla_pkg::ST_OK), res_found == '0)

  // one request in flight: no back-to-back acceptance
  `SLA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

endmodule

bind shifting_array_list_top sla_checker u_sla_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### verif/shifting_array_list_top_tb.sv
// Testbench for shifting_array_list_top: directed and random list operations
// are checked against an in-bench list model. Depends on sla_pkg and the RTL.
module shifting_array_list_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sla_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int RAND_ITEMS = 1000;
  localparam int KEY_POOL_N = 12;
  // Operation codes with no defined action
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  // Traffic shapes for the random part
  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic               at_end;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] payload;
  } list_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found;
    logic [FIELD_W-1:0]  rkey;
    logic [FIELD_W-1:0]  rpay;
    logic [COUNT_W-1:0]  count;
    logic                empty;
  } list_rsp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  shifting_array_list_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock and reset
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Shadow copy of the list
  logic [FIELD_W-1:0] shadow_key [LIST_DEPTH];
  logic [FIELD_W-1:0] shadow_pay [LIST_DEPTH];
  int unsigned        shadow_held = 0;

  list_req_t   req_q[$];
  list_rsp_t   outcome_q[$];
  list_req_t   cur_req;
  int unsigned reqs_taken = 0;
  int unsigned mismatches = 0;
  bit          stim_done = 0;

  // Idle percentages per phase: none, sender, receiver, both
  int unsigned src_idle_pct [4] = '{0, 57, 0, 23};
  int unsigned snk_idle_pct [4] = '{0, 0, 57, 23};
  int unsigned idle_phase;
  assign idle_phase = (reqs_taken / 200) % 4;

  // Apply one request to the shadow list and return the result it yields
  function automatic list_rsp_t apply_list_op(list_req_t r);
    list_rsp_t o;
    o = '{status: ST_OK, found: '0, rkey: '0, rpay: '0, count: '0, empty: 1'b0};
    case (r.op)
      OP_INSERT: begin
        if (shadow_held >= LIST_DEPTH) begin
          o.status = ST_FULL;
        end else if (r.at_end) begin
          shadow_key[shadow_held] = r.key;
          shadow_pay[shadow_held] = r.payload;
          shadow_held++;
        end else if (r.pos >= shadow_held) begin
          o.status = ST_BAD_POS;
        end else begin
          for (int q = shadow_held; q > r.pos; q--) begin
            shadow_key[q] = shadow_key[q-1];
            shadow_pay[q] = shadow_pay[q-1];
          end
          shadow_key[r.pos] = r.key;
          shadow_pay[r.pos] = r.payload;
          shadow_held++;
        end
      end
      OP_DELETE: begin
        if (r.pos >= shadow_held) begin
          o.status = ST_BAD_POS;
        end else begin
          for (int q = r.pos; q + 1 < shadow_held; q++) begin
            shadow_key[q] = shadow_key[q+1];
            shadow_pay[q] = shadow_pay[q+1];
          end
          shadow_held--;
        end
      end
      OP_READ: begin
        if (r.pos >= shadow_held) begin
          o.status = ST_BAD_POS;
        end else begin
          o.rkey = shadow_key[r.pos];
          o.rpay = shadow_pay[r.pos];
        end
      end
      OP_UPDATE: begin
        if (r.pos >= shadow_held) begin
          o.status = ST_BAD_POS;
        end else begin
          shadow_key[r.pos] = r.key;
          shadow_pay[r.pos] = r.payload;
        end
      end
      OP_FIND: begin
        o.status = ST_NOT_FOUND;
        for (int q = 0; q < shadow_held; q++) begin
          if (shadow_key[q] == r.key) begin
            o.status = ST_OK;
            o.found  = POS_W'(q);
            break;
          end
        end
      end
      OP_CLEAR: begin
        shadow_held = 0;
      end
      default: ;
    endcase
    o.count = COUNT_W'(shadow_held);
    o.empty = (shadow_held == 0);
    return o;
  endfunction

  // Request driver: holds tvalid until the request is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(apply_list_op(cur_req));
        reqs_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= src_idle_pct[idle_phase]) begin
          cur_req = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= S_TDATA_W'({cur_req.payload, cur_req.key, cur_req.at_end,
                                  cur_req.pos, cur_req.op});
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct[idle_phase]);
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[OUT_STATUS_LSB +: STATUS_W];
        got.found  = m_tdata[OUT_FOUND_LSB +: POS_W];
        got.rkey   = m_tdata[OUT_KEY_LSB +: FIELD_W];
        got.rpay   = m_tdata[OUT_PAY_LSB +: FIELD_W];
        got.count  = m_tdata[OUT_COUNT_LSB +: COUNT_W];
        got.empty  = m_tdata[OUT_EMPTY_LSB];
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: %h", $realtime, m_tdata);
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.rkey !== want.rkey || got.rpay !== want.rpay ||
              got.count !== want.count || got.empty !== want.empty) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp st=%0d fp=%0d k=%h p=%h n=%0d e=%0b",
                       $realtime, want.status, want.found, want.rkey, want.rpay,
                       want.count, want.empty,
                       " got st=%0d fp=%0d k=%h p=%h n=%0d e=%0b",
                       got.status, got.found, got.rkey, got.rpay,
                       got.count, got.empty);
          end
        end
      end
    end
  end

  // Stimulus
  logic [FIELD_W-1:0] key_pool [KEY_POOL_N];
  int unsigned        gen_held = 0;

  // Queue a request and track the entry count it leaves
  task automatic push_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic at_end,
                          logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] payload);
    req_q.push_back('{op: op, pos: pos, at_end: at_end, key: key, payload: payload});
    case (op)
      OP_INSERT: if (gen_held < LIST_DEPTH && (at_end || pos < gen_held)) gen_held++;
      OP_DELETE: if (pos < gen_held) gen_held--;
      OP_CLEAR:  gen_held = 0;
      default: ;
    endcase
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    if (gen_held > 0 && $urandom_range(99) < 85)
      return POS_W'($urandom_range(gen_held - 1));
    if ($urandom_range(1) == 1 && gen_held < LIST_DEPTH)
      return POS_W'(gen_held);
    return POS_W'($urandom_range(LIST_DEPTH - 1));
  endfunction

  function automatic logic [FIELD_W-1:0] pick_key();
    if ($urandom_range(99) < 80)
      return key_pool[$urandom_range(KEY_POOL_N - 1)];
    return $urandom;
  endfunction

  initial begin
    traffic_mode_t mode;
    int unsigned   roll;
    int unsigned   ins_pct;
    int unsigned   del_pct;
    logic [OP_W-1:0] op;

    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    // Empty list corner cases
    push_req(OP_READ,   5'd0,  1'b0, '0, '0);
    push_req(OP_DELETE, 5'd0,  1'b0, '0, '0);
    push_req(OP_UPDATE, 5'd31, 1'b0, '1, '1);
    push_req(OP_FIND,   5'd0,  1'b0, '0, '0);
    push_req(OP_INSERT, 5'd0,  1'b0, '1, '1);
    push_req(OP_SPARE_A, 5'd3, 1'b1, '1, '1);
    push_req(OP_SPARE_B, 5'd31, 1'b0, '0, '0);
    // Build a few entries, then exercise each operation
    push_req(OP_INSERT, 5'd31, 1'b1, '0, '1);
    push_req(OP_INSERT, 5'd0,  1'b1, '1, '0);
    push_req(OP_INSERT, 5'd0,  1'b0, 32'h1234_5678, 32'h9abc_def0);
    push_req(OP_INSERT, 5'd1,  1'b0, 32'h5555_aaaa, 32'haaaa_5555);
    push_req(OP_READ,   5'd0,  1'b0, '0, '0);
    push_req(OP_READ,   5'd3,  1'b0, '0, '0);
    push_req(OP_READ,   5'd4,  1'b0, '0, '0);
    push_req(OP_UPDATE, 5'd2,  1'b0, 32'hdead_beef, 32'h0bad_f00d);
    push_req(OP_FIND,   5'd0,  1'b0, '1, '0);
    push_req(OP_FIND,   5'd0,  1'b0, 32'hdead_beef, '0);
    push_req(OP_FIND,   5'd0,  1'b0, 32'h0000_0001, '0);
    push_req(OP_DELETE, 5'd3,  1'b0, '0, '0);
    push_req(OP_DELETE, 5'd0,  1'b0, '0, '0);
    push_req(OP_READ,   5'd1,  1'b0, '0, '0);
    push_req(OP_CLEAR,  5'd31, 1'b1, '1, '1);
    push_req(OP_READ,   5'd0,  1'b0, '0, '0);

    // Random part in blocks that grow, shrink or churn the list
    mode = MODE_MIXED;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 48 == 0) begin
        roll = $urandom_range(2);
        mode = traffic_mode_t'(roll);
      end
      case (mode)
        MODE_GROW:   begin ins_pct = 80; del_pct = 5;  end
        MODE_SHRINK: begin ins_pct = 10; del_pct = 55; end
        default:     begin ins_pct = 30; del_pct = 25; end
      endcase
      roll = $urandom_range(99);
      if (roll < ins_pct)                     op = OP_INSERT;
      else if (roll < ins_pct + del_pct)      op = OP_DELETE;
      else if (roll < 97) begin
        case ($urandom_range(2))
          0:       op = OP_READ;
          1:       op = OP_UPDATE;
          default: op = OP_FIND;
        endcase
      end else if (roll < 98)                 op = OP_CLEAR;
      else if (roll < 99)                     op = OP_SPARE_A;
      else                                    op = OP_SPARE_B;
      push_req(op, pick_pos(), ($urandom_range(99) < 40), pick_key(), $urandom);
    end

    // Drain: all requests taken, then every result back
    while (req_q.size() > 0 || s_tvalid) @(posedge clk);
    while (outcome_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
